>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the velocity key scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/vks_pkg.sv
// Shared types and constants of the velocity key scanner.
package vks_pkg;

	localparam int NUM_KEYS = 128;
	localparam int IDX_W    = $clog2(NUM_KEYS);
	localparam int KEY_W    = 7;
	localparam logic [KEY_W:0] KEY_LIMIT = (KEY_W+1)'(NUM_KEYS);

	localparam int TIME_W = 32;
	localparam int TW_W   = 16;
	localparam int VEL_W  = 7;
	localparam int CH_W   = 4;
	localparam int CFG_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_W  = TW_W + VEL_W;

	localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
	localparam logic [7:0] PITCH_MAX      = 8'd127;

	localparam logic [TW_W-1:0]  TW_MIN_RST  = 16'd8;
	localparam logic [TW_W-1:0]  TW_MAX_RST  = 16'd28;
	localparam logic [VEL_W-1:0] VEL_MIN_RST = 7'd127;
	localparam logic [VEL_W-1:0] VEL_MAX_RST = 7'd54;
	localparam logic [CH_W-1:0]  CHAN_RST    = 4'd0;
	localparam logic [VEL_W-1:0] OFFS_RST    = 7'd19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TW_MIN  = 3'd0,
		REG_TW_MAX  = 3'd1,
		REG_VEL_MIN = 3'd2,
		REG_VEL_MAX = 3'd3,
		REG_CHANNEL = 3'd4,
		REG_OFFSET  = 3'd5
	} vks_reg_t;

	typedef enum logic [1:0] {
		BYTE_STATUS,
		BYTE_PITCH,
		BYTE_VEL
	} vks_byte_t;

	typedef struct packed {
		logic      capture;
		logic      wr_first;
		logic      wr_second;
		logic      ld_diff;
		logic      ld_prep;
		logic      ld_mul;
		logic      div_step;
		logic      ld_vel;
		logic      vel_zero;
		logic      emit;
		vks_byte_t byte_sel;
	} vks_cmd_t;

	typedef struct packed {
		logic in_range;
		logic is_first;
		logic changed;
		logic level;
		logic out_free;
	} vks_stat_t;

endpackage

>>> rtl/core/vks_dp.sv
// Datapath: config registers, key state, contact time memory, velocity math, output register.
module vks_dp import vks_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [KEY_W-1:0]     key_index,
	input  logic                 contact_select,
	input  logic                 contact_level,
	input  logic [TIME_W-1:0]    time_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           midi_byte,
	output logic                 last_byte,
	input  vks_cmd_t             cmd,
	output vks_stat_t            stat
);

	logic [TW_W-1:0]  tw_min_q, tw_max_q;
	logic [VEL_W-1:0] vel_min_q, vel_max_q, offset_q;
	logic [CH_W-1:0]  chan_q;

	logic [KEY_W-1:0]  key_q;
	logic              sel_q, level_q;
	logic [TIME_W-1:0] now_q;

	logic [NUM_KEYS-1:0] lvl1_q, lvl2_q, tvld_q;
	logic [TIME_W-1:0]   time_mem [NUM_KEYS];
	logic [TIME_W-1:0]   trd_q;
	logic                tvld_rd_q;

	logic [TIME_W-1:0] diff_q;
	logic [TW_W-1:0]   c_q, r_q;
	logic [VEL_W-1:0]  span_q, quo_q, vel_q;
	logic              up_q, inv_q;
	logic [DIV_W-1:0]  rem_q, dvs_q;

	logic              out_valid_q, last_q;
	logic [7:0]        byte_q;

	logic [IDX_W-1:0]  idx;
	logic [TIME_W-1:0] base;
	logic              d_lo, d_hi, ge;
	logic [TW_W-1:0]   clamped;
	logic [7:0]        pitch_sum, pitch, byte_d;
	logic [VEL_W-1:0]  vel_calc;

	assign idx = key_q[IDX_W-1:0];

	assign stat.in_range = {1'b0, key_q} < KEY_LIMIT;
	assign stat.is_first = !sel_q;
	assign stat.changed  = sel_q ? (level_q != lvl2_q[idx]) : (level_q != lvl1_q[idx]);
	assign stat.level    = level_q;
	assign stat.out_free = !out_valid_q || !out_stall;

	// never-written time entries read as zero
	assign base = tvld_rd_q ? trd_q : '0;

	assign d_lo = diff_q < TIME_W'(tw_min_q);
	assign d_hi = diff_q > TIME_W'(tw_max_q);
	assign clamped = d_lo ? tw_min_q : (d_hi ? tw_max_q : diff_q[TW_W-1:0]);

	assign ge = rem_q >= dvs_q;

	always_comb begin
		if (inv_q)
			vel_calc = '0;
		else if (r_q == '0)
			vel_calc = vel_min_q;
		else if (up_q)
			vel_calc = vel_min_q + quo_q;
		else
			vel_calc = vel_min_q - quo_q;
	end

	assign pitch_sum = {1'b0, key_q} + {1'b0, offset_q};
	assign pitch     = (pitch_sum > PITCH_MAX) ? PITCH_MAX : pitch_sum;

	always_comb begin
		case (cmd.byte_sel)
			BYTE_STATUS: byte_d = STATUS_NOTE_ON + {4'b0, chan_q};
			BYTE_PITCH:  byte_d = pitch;
			BYTE_VEL:    byte_d = {1'b0, vel_q};
			default:     byte_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_min_q  <= TW_MIN_RST;
			tw_max_q  <= TW_MAX_RST;
			vel_min_q <= VEL_MIN_RST;
			vel_max_q <= VEL_MAX_RST;
			chan_q    <= CHAN_RST;
			offset_q  <= OFFS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TW_MIN:  tw_min_q  <= cfg_data[TW_W-1:0];
				REG_TW_MAX:  tw_max_q  <= cfg_data[TW_W-1:0];
				REG_VEL_MIN: vel_min_q <= cfg_data[VEL_W-1:0];
				REG_VEL_MAX: vel_max_q <= cfg_data[VEL_W-1:0];
				REG_CHANNEL: chan_q    <= cfg_data[CH_W-1:0];
				REG_OFFSET:  offset_q  <= cfg_data[VEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl1_q <= '0;
			lvl2_q <= '0;
			tvld_q <= '0;
		end else begin
			if (cmd.wr_first) begin
				lvl1_q[idx] <= level_q;
				tvld_q[idx] <= 1'b1;
			end
			if (cmd.wr_second)
				lvl2_q[idx] <= level_q;
		end
	end

	// contact time memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_first)
			time_mem[idx] <= now_q;
		if (cmd.capture) begin
			trd_q     <= time_mem[key_index[IDX_W-1:0]];
			tvld_rd_q <= tvld_q[key_index[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q   <= key_index;
			sel_q   <= contact_select;
			level_q <= contact_level;
			now_q   <= time_ms;
		end
		if (cmd.ld_diff)
			diff_q <= now_q - base;
		if (cmd.ld_prep) begin
			c_q    <= clamped - tw_min_q;
			r_q    <= tw_max_q - tw_min_q;
			inv_q  <= tw_min_q > tw_max_q;
			up_q   <= vel_max_q > vel_min_q;
			span_q <= (vel_max_q > vel_min_q) ? vel_max_q - vel_min_q : vel_min_q - vel_max_q;
		end
		if (cmd.ld_mul) begin
			rem_q <= DIV_W'(c_q) * DIV_W'(span_q);
			dvs_q <= DIV_W'(r_q) << (VEL_W - 1);
			quo_q <= '0;
		end
		// restoring divide, one quotient bit per step, MSB first
		if (cmd.div_step) begin
			if (ge)
				rem_q <= rem_q - dvs_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[VEL_W-2:0], ge};
		end
		if (cmd.ld_vel)
			vel_q <= vel_calc;
		else if (cmd.vel_zero)
			vel_q <= '0;
		if (cmd.emit) begin
			byte_q <= byte_d;
			last_q <= cmd.byte_sel == BYTE_VEL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign midi_byte = byte_q;
	assign last_byte = last_q;

endmodule

>>> rtl/core/vks_ctrl.sv
// Controller state machine: sequences lookup, velocity math and the three output bytes.
module vks_ctrl import vks_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  vks_stat_t stat,
	output vks_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_CLAMP,
		S_MUL,
		S_DIV,
		S_FIN,
		S_OUT0,
		S_OUT1,
		S_OUT2
	} state_t;

	localparam logic [2:0] LAST_STEP = 3'(VEL_W - 1);

	state_t     state_q, state_d;
	logic [2:0] cnt_q;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd      = '0;
		cmd.byte_sel = BYTE_STATUS;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid)
					state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_IDLE;
				if (stat.in_range && stat.changed) begin
					if (stat.is_first) begin
						cmd.wr_first = 1'b1;
					end else begin
						cmd.wr_second = 1'b1;
						if (stat.level) begin
							cmd.ld_diff = 1'b1;
							state_d = S_CLAMP;
						end else begin
							cmd.vel_zero = 1'b1;
							state_d = S_OUT0;
						end
					end
				end
			end
			S_CLAMP: begin
				cmd.ld_prep = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.ld_mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == LAST_STEP)
					state_d = S_FIN;
			end
			S_FIN: begin
				cmd.ld_vel = 1'b1;
				state_d = S_OUT0;
			end
			S_OUT0: begin
				cmd.byte_sel = BYTE_STATUS;
				cmd.emit = stat.out_free;
				if (stat.out_free)
					state_d = S_OUT1;
			end
			S_OUT1: begin
				cmd.byte_sel = BYTE_PITCH;
				cmd.emit = stat.out_free;
				if (stat.out_free)
					state_d = S_OUT2;
			end
			S_OUT2: begin
				cmd.byte_sel = BYTE_VEL;
				cmd.emit = stat.out_free;
				if (stat.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV)
				cnt_q <= cnt_q + 3'd1;
			else
				cnt_q <= '0;
		end
	end

endmodule

>>> rtl/core/velocity_key_scanner_midi.sv
// Velocity key scanner top level: turns contact readings into MIDI note-on bytes.
//
// Each input transfer is one contact reading of one key. A first-contact reading passes
// through capture and state update. A second-contact release passes through capture and
// state update, then the three output byte transfers. A press passes through capture,
// time difference, clamp, one multiply, a seven-step restoring divide that yields one
// quotient bit per cycle and velocity load, then the three byte transfers.
// One reading is in work at a time; the last byte waits in the output register while the
// next reading is taken. Contact levels and the contact-time valid bits are flops
// cleared by reset; the contact-time memory needs no clearing pass.
`include "assert_macros.svh"

module velocity_key_scanner_midi import vks_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [KEY_W-1:0]     key_index,
	input  logic                 contact_select,
	input  logic                 contact_level,
	input  logic [TIME_W-1:0]    time_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           midi_byte,
	output logic                 last_byte
);

	vks_cmd_t  cmd;
	vks_stat_t stat;

	vks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	vks_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.key_index      (key_index),
		.contact_select (contact_select),
		.contact_level  (contact_level),
		.time_ms        (time_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.midi_byte      (midi_byte),
		.last_byte      (last_byte),
		.cmd            (cmd),
		.stat           (stat)
	);

	`ASSERT_CLK(a_emit_free, cmd.emit |-> stat.out_free, "byte loaded over a pending byte")
	`ASSERT_CLK(a_busy_after, (in_valid && !in_stall) |=> in_stall, "input taken while busy")
	`ASSERT_NEVER(a_wr_excl, cmd.wr_first && cmd.wr_second, "both contact stores written")

endmodule

>>> dv/velocity_key_scanner_midi_test.sv
// Testbench for the velocity key scanner: contact readings in, checked MIDI note-on bytes out.
`timescale 1ns / 100ps

module velocity_key_scanner_midi_test;
	import vks_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_WAIT  = 40;
	localparam int PHASE_ITEMS  = 68;
	localparam int NUM_PHASES   = 6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam bit FIRST_CONTACT  = 1'b0;
	localparam bit SECOND_CONTACT = 1'b1;

	typedef struct {
		bit [7:0] value;
		bit       last;
	} note_byte_t;

	class note_on_scoreboard;
		bit [TW_W-1:0]  tw_min, tw_max;
		bit [VEL_W-1:0] vel_lo, vel_hi;
		bit [CH_W-1:0]  chan;
		bit [VEL_W-1:0] offs;
		bit             first_lvl[NUM_KEYS];
		bit             second_lvl[NUM_KEYS];
		bit [TIME_W-1:0] first_stamp[NUM_KEYS];
		note_byte_t     pending[$];
		int             errors;

		function new();
			tw_min = TW_MIN_RST;
			tw_max = TW_MAX_RST;
			vel_lo = VEL_MIN_RST;
			vel_hi = VEL_MAX_RST;
			chan   = CHAN_RST;
			offs   = OFFS_RST;
			foreach (first_lvl[k]) begin
				first_lvl[k]   = 1'b0;
				second_lvl[k]  = 1'b0;
				first_stamp[k] = '0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_TW_MIN:  tw_min = data[TW_W-1:0];
				REG_TW_MAX:  tw_max = data[TW_W-1:0];
				REG_VEL_MIN: vel_lo = data[VEL_W-1:0];
				REG_VEL_MAX: vel_hi = data[VEL_W-1:0];
				REG_CHANNEL: chan   = data[CH_W-1:0];
				REG_OFFSET:  offs   = data[VEL_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [VEL_W-1:0] strike_velocity(bit [TIME_W-1:0] gap_ms);
			bit [31:0] c, r, q;
			if (tw_min > tw_max)
				return '0;
			if (gap_ms < TIME_W'(tw_min))
				gap_ms = TIME_W'(tw_min);
			if (gap_ms > TIME_W'(tw_max))
				gap_ms = TIME_W'(tw_max);
			c = gap_ms - TIME_W'(tw_min);
			r = 32'(tw_max) - 32'(tw_min);
			if (r == 0)
				return vel_lo;
			if (vel_hi > vel_lo) begin
				q = (c * 32'(vel_hi - vel_lo)) / r;
				return VEL_W'(vel_lo + q);
			end
			q = (c * 32'(vel_lo - vel_hi)) / r;
			return VEL_W'(vel_lo - q);
		endfunction

		function void note_reading(bit [KEY_W-1:0] key, bit sel, bit lvl, bit [TIME_W-1:0] stamp);
			bit [7:0] pitch;
			bit [7:0] vel;
			if (sel == FIRST_CONTACT) begin
				if (lvl != first_lvl[key]) begin
					first_lvl[key]   = lvl;
					first_stamp[key] = stamp;
				end
				return;
			end
			if (lvl == second_lvl[key])
				return;
			second_lvl[key] = lvl;
			pitch = 8'(key) + 8'(offs);
			if (pitch > PITCH_MAX)
				pitch = PITCH_MAX;
			vel = lvl ? 8'(strike_velocity(stamp - first_stamp[key])) : 8'd0;
			pending.push_back('{STATUS_NOTE_ON + 8'(chan), 1'b0});
			pending.push_back('{pitch, 1'b0});
			pending.push_back('{vel, 1'b1});
		endfunction

		function void check_byte(logic [7:0] value, logic last);
			note_byte_t exp_byte;
			if (pending.size() == 0) begin
				$display("%0t: unexpected byte, expected none, actual %h last %b",
					$time, value, last);
				errors++;
				return;
			end
			exp_byte = pending.pop_front();
			if (value !== exp_byte.value) begin
				$display("%0t: midi_byte mismatch, expected %h, actual %h",
					$time, exp_byte.value, value);
				errors++;
			end
			if (last !== exp_byte.last) begin
				$display("%0t: last_byte mismatch, expected %b, actual %b",
					$time, exp_byte.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [KEY_W-1:0]     key_index;
	logic                 contact_select;
	logic                 contact_level;
	logic [TIME_W-1:0]    time_ms;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           midi_byte;
	logic                 last_byte;

	note_on_scoreboard sb;
	bit                no_idle;
	bit [TIME_W-1:0]   now_ms;
	int                items_sent;
	int                cycles;

	velocity_key_scanner_midi uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.key_index      (key_index),
		.contact_select (contact_select),
		.contact_level  (contact_level),
		.time_ms        (time_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.midi_byte      (midi_byte),
		.last_byte      (last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(midi_byte, last_byte);

	initial begin
		int n;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// call at a rising edge; returns at the edge of the transfer
	task automatic send_reading(bit [KEY_W-1:0] key, bit sel, bit lvl, bit [TIME_W-1:0] stamp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		key_index      <= key;
		contact_select <= sel;
		contact_level  <= lvl;
		time_ms        <= stamp;
		do @(posedge clk); while (in_stall);
		sb.note_reading(key, sel, lvl, stamp);
		items_sent++;
	endtask

	// first-contact readings give no bytes, so hold a while after the queue empties
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic program_regs(bit [TW_W-1:0] tmin, bit [TW_W-1:0] tmax, bit [VEL_W-1:0] vlo,
			bit [VEL_W-1:0] vhi, bit [CH_W-1:0] ch, bit [VEL_W-1:0] offset);
		vks_reg_t        order[6];
		int              widths[6];
		bit [CFG_W-1:0]  vals[6];
		logic [CFG_W-1:0] data;
		order  = '{REG_TW_MIN, REG_TW_MAX, REG_VEL_MIN, REG_VEL_MAX, REG_CHANNEL, REG_OFFSET};
		widths = '{TW_W, TW_W, VEL_W, VEL_W, CH_W, VEL_W};
		vals   = '{tmin, tmax, CFG_W'(vlo), CFG_W'(vhi), CFG_W'(ch), CFG_W'(offset)};
		// writes to unused indexes must be dropped
		data = CFG_W'($urandom());
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SPARE_A;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(REG_SPARE_A, data);
		for (int i = 0; i < 6; i++) begin
			// junk above the register width must be masked off
			data = CFG_W'(vals[i] | ($urandom() << widths[i]));
			cfg_index <= order[i];
			cfg_data  <= data;
			@(posedge clk);
			sb.write_reg(order[i], data);
		end
		data = CFG_W'($urandom());
		cfg_index <= REG_SPARE_B;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(REG_SPARE_B, data);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic play_strike();
		bit [KEY_W-1:0]  key;
		bit [TIME_W-1:0] gap_ms;
		key = KEY_W'($urandom_range(0, NUM_KEYS - 1));
		case ($urandom_range(0, 9))
			0: gap_ms = sb.tw_min - $urandom_range(0, 3);
			1: gap_ms = sb.tw_max + $urandom_range(0, 5);
			2: gap_ms = $urandom();
			3: gap_ms = TIME_W'(sb.tw_min);
			4: gap_ms = TIME_W'(sb.tw_max);
			default: gap_ms = $urandom_range(sb.tw_min, sb.tw_max);
		endcase
		send_reading(key, FIRST_CONTACT, 1'b1, now_ms);
		now_ms += gap_ms;
		send_reading(key, SECOND_CONTACT, 1'b1, now_ms);
		now_ms += $urandom_range(1, 500);
		send_reading(key, SECOND_CONTACT, 1'b0, now_ms);
		now_ms += $urandom_range(0, 40);
		send_reading(key, FIRST_CONTACT, 1'b0, now_ms);
	endtask

	task automatic play_noise();
		now_ms += $urandom_range(0, 30);
		send_reading(KEY_W'($urandom_range(0, NUM_KEYS - 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0) ? $urandom() : now_ms);
	endtask

	initial begin
		int phase_end;
		bit [TW_W-1:0] tmin, tmax;
		sb         = new();
		no_idle    = 1'b0;
		items_sent = 0;
		arst_n     <= 1'b0;
		cfg_wr_en  <= 1'b0;
		cfg_index  <= REG_TW_MIN;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		key_index  <= '0;
		contact_select <= 1'b0;
		contact_level  <= 1'b0;
		time_ms    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: falling velocity curve over 8..28 ms
		send_reading(7'd5, SECOND_CONTACT, 1'b1, 32'd15);   // first contact never touched
		send_reading(7'd5, SECOND_CONTACT, 1'b1, 32'd20);   // no change, no bytes
		send_reading(7'd5, SECOND_CONTACT, 1'b0, 32'd30);
		send_reading(7'd0, FIRST_CONTACT, 1'b1, 32'd100);
		send_reading(7'd0, SECOND_CONTACT, 1'b1, 32'd103);  // below window
		send_reading(7'd0, FIRST_CONTACT, 1'b1, 32'd110);   // keep first time
		send_reading(7'd0, SECOND_CONTACT, 1'b0, 32'd150);
		send_reading(7'd0, SECOND_CONTACT, 1'b1, 32'd200);  // above window
		send_reading(7'd127, FIRST_CONTACT, 1'b1, 32'hFFFF_FFF8);
		send_reading(7'd127, SECOND_CONTACT, 1'b1, 32'h0000_0006); // wraps, pitch saturates
		send_reading(7'd127, FIRST_CONTACT, 1'b0, 32'h0000_0010);
		send_reading(7'd127, SECOND_CONTACT, 1'b0, 32'h0000_0011);
		send_reading(7'd64, FIRST_CONTACT, 1'b1, 32'hAAAA_5555);
		send_reading(7'd64, SECOND_CONTACT, 1'b1, 32'hAAAA_5567);
		send_reading(7'd64, SECOND_CONTACT, 1'b0, 32'h5555_AAAA);
		send_reading(7'd64, FIRST_CONTACT, 1'b0, 32'h5555_AAAB);
		settle();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: program_regs(16'd0, 16'hFFFF, 7'd0, 7'd127, 4'hF, 7'd127);
				1: begin
					tmin = TW_W'($urandom_range(0, 60));
					tmax = TW_W'(tmin + $urandom_range(1, 300));
					program_regs(tmin, tmax, VEL_W'($urandom_range(64, 127)),
						VEL_W'($urandom_range(0, 63)), CH_W'($urandom()),
						VEL_W'($urandom()));
				end
				2: begin
					// inverted window
					tmin = TW_W'($urandom_range(30, 200));
					tmax = TW_W'($urandom_range(0, tmin - 1));
					program_regs(tmin, tmax, VEL_W'($urandom()), VEL_W'($urandom()),
						CH_W'($urandom()), VEL_W'($urandom()));
				end
				3: program_regs(16'hFFFF, 16'hFFFF, 7'd127, 7'd0, 4'h0, 7'd0);
				4: begin
					tmin = TW_W'($urandom_range(0, 50));
					program_regs(tmin, tmin, VEL_W'($urandom()), VEL_W'($urandom()),
						CH_W'($urandom()), VEL_W'($urandom()));
				end
				default: program_regs(TW_W'($urandom_range(0, 100)),
					TW_W'($urandom_range(0, 400)), VEL_W'($urandom()), VEL_W'($urandom()),
					CH_W'($urandom()), VEL_W'($urandom()));
			endcase
			now_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom();
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 19) == 0)
					no_idle = !no_idle;
				if ($urandom_range(0, 3) == 0)
					play_noise();
				else
					play_strike();
			end
			no_idle = 1'b0;
			settle();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
